FILE: hdl/png_stored_deflate_writer_macros.svh
// assertion macros shared by the png stored-deflate writer checkers
// no dependencies; assumes clock and reset are in scope at the use site
`ifndef PNG_STORED_DEFLATE_WRITER_MACROS_SVH
`define PNG_STORED_DEFLATE_WRITER_MACROS_SVH

// same-cycle implication, off during reset
`define PSDW_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("png writer check failed");

// next-cycle implication, off during reset
`define PSDW_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("png writer check failed");

// next-cycle implication that also holds across reset
`define PSDW_ASSERT_RST(name, ante, cons) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("png writer check failed");

`endif

FILE: hdl/psdw_pkg.sv
// shared types, constants and byte helpers of the png stored-deflate writer
// no dependencies
package psdw_pkg;

   localparam int DIM_BITS_DEF  = 16;
   localparam int BLOCK_MAX_DEF = 65535;
   localparam int CFG_W         = 16;
   localparam int CSR_IDX_W     = 1;
   localparam int STEP_W        = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
   localparam logic [16:0] ADLER_MOD  = 17'd65521;
   localparam logic [31:0] ADLER_INIT = 32'h0000_0001;

   localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
   localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
   localparam logic [31:0] IHDR_LEN  = 32'd13;
   localparam logic [7:0]  BIT_DEPTH = 8'h01;
   localparam logic [7:0]  ZLIB_CMF  = 8'h78;
   localparam logic [7:0]  ZLIB_FLG  = 8'h01;
   localparam logic [7:0]  FILTER_NONE = 8'h00;

   localparam logic [7:0] PNG_SIG [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                         8'd13, 8'd10, 8'd26, 8'd10};

   // byte positions of the header run
   localparam logic [STEP_W-1:0] ST_LEN      = 6'd8;
   localparam logic [STEP_W-1:0] ST_IHDR     = 6'd12;
   localparam logic [STEP_W-1:0] ST_WIDTH    = 6'd16;
   localparam logic [STEP_W-1:0] ST_HEIGHT   = 6'd20;
   localparam logic [STEP_W-1:0] ST_DEPTH    = 6'd24;
   localparam logic [STEP_W-1:0] ST_CRC      = 6'd29;
   localparam logic [STEP_W-1:0] ST_IDAT_LEN = 6'd33;
   localparam logic [STEP_W-1:0] ST_IDAT     = 6'd37;
   localparam logic [STEP_W-1:0] ST_CMF      = 6'd41;
   localparam logic [STEP_W-1:0] ST_FLG      = 6'd42;
   localparam logic [STEP_W-1:0] ST_DIV_LOAD = 6'd2;

   // byte positions of the trailer run
   localparam logic [STEP_W-1:0] FN_CRC  = 6'd4;
   localparam logic [STEP_W-1:0] FN_LEN  = 6'd8;
   localparam logic [STEP_W-1:0] FN_IEND = 6'd12;
   localparam logic [STEP_W-1:0] FN_CRC2 = 6'd16;
   localparam logic [STEP_W-1:0] FN_LAST = 6'd19;

   localparam logic [STEP_W-1:0] BH_LAST = 6'd4;
   localparam logic [STEP_W-1:0] BH_LEN_LO  = 6'd1;
   localparam logic [STEP_W-1:0] BH_LEN_HI  = 6'd2;
   localparam logic [STEP_W-1:0] BH_NLEN_LO = 6'd3;

   typedef struct packed {
      logic       func;
      logic [7:0] pixel_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       end_of_file;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_RUN  = 3'b010,
      PH_DONE = 3'b100
   } phase_type;

   typedef enum logic [4:0] {
      MD_NEW   = 5'b00001,
      MD_START = 5'b00010,
      MD_BHDR  = 5'b00100,
      MD_RAW   = 5'b01000,
      MD_FIN   = 5'b10000
   } mode_type;

   typedef struct packed {
      logic latch;
      logic div_load;
   } geom_ctl_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
      end
      return r;
   endfunction

   // big-endian byte k of a word
   function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
      logic [7:0] r;
      unique case (k)
         2'd0: r = v[31:24];
         2'd1: r = v[23:16];
         2'd2: r = v[15:8];
         default: r = v[7:0];
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/png_stored_deflate_writer.sv
// bytes of an item go from the item register to the output register; one output byte a cycle
// unless the output stalls or the IDAT length bytes wait for the block count, which is
// loaded at the third header byte; an item holds the input until its bytes are out (one for
// most pixel bytes, up to twelve at row and block starts, 43 for a start, 20 more at end)
// reset is synchronous: idle, 1x1 geometry, no item held, output empty
module png_stored_deflate_writer #(
   parameter int DIM_BITS  = psdw_pkg::DIM_BITS_DEF,
   parameter int BLOCK_MAX = psdw_pkg::BLOCK_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  psdw_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output psdw_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [psdw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [psdw_pkg::CFG_W-1:0]    csr_wdata
);
   import psdw_pkg::*;

   localparam int TOT_W = 2 * DIM_BITS + 1;

   logic [CFG_W-1:0]    width_ff, height_ff;
   logic                item_valid_ff;
   req_type             item_ff;
   logic                item_done;
   geom_ctl_type        ctl;
   logic [DIM_BITS-1:0] img_width, img_height, row_len;
   logic [TOT_W-1:0]    raw_total;
   logic [31:0]         idat_len;
   logic                len_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(1);
         height_ff <= CFG_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: width_ff <= width_ff;
         endcase
      end
   end

   assign req_stall = item_valid_ff && !item_done;

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_data;
      end
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   psdw_geom #(
      .DIM_BITS  (DIM_BITS),
      .BLOCK_MAX (BLOCK_MAX),
      .TOT_W     (TOT_W)
   ) u_geom (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .width_reg  (width_ff),
      .height_reg (height_ff),
      .img_width  (img_width),
      .img_height (img_height),
      .row_len    (row_len),
      .raw_total  (raw_total),
      .idat_len   (idat_len),
      .len_ready  (len_ready)
   );

   psdw_emit #(
      .DIM_BITS  (DIM_BITS),
      .BLOCK_MAX (BLOCK_MAX),
      .TOT_W     (TOT_W)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .item_done  (item_done),
      .ctl        (ctl),
      .img_width  (img_width),
      .img_height (img_height),
      .row_len    (row_len),
      .raw_total  (raw_total),
      .idat_len   (idat_len),
      .len_ready  (len_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: hdl/psdw_geom.sv
// image geometry latch, raw size multiplier and block count by reciprocal multiply
// depends on psdw_pkg
module psdw_geom #(
   parameter int DIM_BITS  = psdw_pkg::DIM_BITS_DEF,
   parameter int BLOCK_MAX = psdw_pkg::BLOCK_MAX_DEF,
   parameter int TOT_W     = 2 * DIM_BITS + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  psdw_pkg::geom_ctl_type      ctl,
   input  logic [psdw_pkg::CFG_W-1:0]  width_reg,
   input  logic [psdw_pkg::CFG_W-1:0]  height_reg,
   output logic [DIM_BITS-1:0]         img_width,
   output logic [DIM_BITS-1:0]         img_height,
   output logic [DIM_BITS-1:0]         row_len,
   output logic [TOT_W-1:0]            raw_total,
   output logic [31:0]                 idat_len,
   output logic                        len_ready
);
   import psdw_pkg::*;

   // dividend bound: rounded-up raw size stays below 2^(2*CFG_W-1)
   localparam int DV_W = 2 * CFG_W - 1;
   localparam int RL   = $clog2(BLOCK_MAX);
   localparam int SH   = DV_W + RL;
   localparam int RC_W = DV_W + 1;
   localparam int PR_W = DV_W + RC_W;
   localparam logic [RC_W-1:0] RECIP =
      RC_W'(((64'd1 << SH) + 64'(BLOCK_MAX) - 64'd1) / 64'(BLOCK_MAX));

   logic [DIM_BITS-1:0] w_dim, h_dim, rb_dim;
   logic [DIM_BITS-1:0] w_ff, h_ff, rb_ff;
   logic [TOT_W-1:0]    total_ff;
   logic [DV_W-1:0]     dvd_ff;
   logic [PR_W-1:0]     prod_ff;
   logic [31:0]         nblk_ff;
   logic [1:0]          ld_ff;
   logic                done_ff;
   logic [DIM_BITS+2:0] rb_wide;

   always_comb begin
      w_dim = DIM_BITS'(width_reg);
      h_dim = DIM_BITS'(height_reg);
      if (w_dim == '0) begin
         w_dim = DIM_BITS'(1);
      end
      if (h_dim == '0) begin
         h_dim = DIM_BITS'(1);
      end
      rb_wide = ({3'b000, w_dim} + (DIM_BITS+3)'(7)) >> 3;
      rb_dim  = DIM_BITS'(rb_wide);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff  <= DIM_BITS'(1);
         h_ff  <= DIM_BITS'(1);
         rb_ff <= DIM_BITS'(1);
      end else if (ctl.latch) begin
         w_ff  <= w_dim;
         h_ff  <= h_dim;
         rb_ff <= rb_dim;
      end
   end

   // one multiply, registered
   always_ff @(posedge clock) begin
      total_ff <= TOT_W'({1'b0, rb_ff} + (DIM_BITS+1)'(1)) * TOT_W'(h_ff);
   end

   // rounded-up block count: load, reciprocal multiply, shift
   always_ff @(posedge clock) begin
      if (ctl.div_load) begin
         dvd_ff <= DV_W'(total_ff) + DV_W'(BLOCK_MAX - 1);
      end
      prod_ff <= PR_W'(dvd_ff) * PR_W'(RECIP);
      nblk_ff <= 32'(prod_ff >> SH);
      if (reset) begin
         ld_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         ld_ff <= {ld_ff[0], ctl.div_load};
         if (ctl.div_load) begin
            done_ff <= 1'b0;
         end else if (ld_ff[1]) begin
            done_ff <= 1'b1;
         end
      end
   end

   assign img_width  = w_ff;
   assign img_height = h_ff;
   assign row_len    = rb_ff;
   assign raw_total  = total_ff;
   assign idat_len   = 32'(total_ff) + nblk_ff + (nblk_ff << 2) + 32'd6;
   assign len_ready  = done_ff;

endmodule

FILE: hdl/psdw_emit.sv
// byte sequencer: headers, block framing, raw bytes, trailer, running crc and adler
// depends on psdw_pkg; geometry comes from psdw_geom
module psdw_emit #(
   parameter int DIM_BITS  = psdw_pkg::DIM_BITS_DEF,
   parameter int BLOCK_MAX = psdw_pkg::BLOCK_MAX_DEF,
   parameter int TOT_W     = 2 * DIM_BITS + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  psdw_pkg::req_type      item,
   output logic                   item_done,
   output psdw_pkg::geom_ctl_type ctl,
   input  logic [DIM_BITS-1:0]    img_width,
   input  logic [DIM_BITS-1:0]    img_height,
   input  logic [DIM_BITS-1:0]    row_len,
   input  logic [TOT_W-1:0]       raw_total,
   input  logic [31:0]            idat_len,
   input  logic                   len_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output psdw_pkg::rsp_type      rsp_data
);
   import psdw_pkg::*;

   localparam int CMP_W = TOT_W + 17;

   phase_type           phase_ff, phase_in;
   mode_type            mode_ff, mode_in, eff_mode;
   logic [STEP_W-1:0]   cnt_ff, cnt_in, cnt;
   logic                filt_ff, filt_in, filt;
   logic [31:0]         crc_ff, crc_in, crc_src;
   logic [31:0]         adler_ff, adler_in;
   logic [DIM_BITS-1:0] bir_ff, bir_in, row_ff, row_in;
   logic [15:0]         bf_ff, bf_in;
   logic [TOT_W-1:0]    off_ff, off_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                can_emit, drop, want, hold, fire, last, eof, use_crc;
   logic [7:0]          obyte, raw_b;
   logic [1:0]          k_al, k_off;
   logic [STEP_W-1:0]   cnt_m1;
   logic [TOT_W-1:0]    rem_len;
   logic                blk_last;
   logic [15:0]         len16;
   logic [16:0]         a1, a2, bf_inc;
   logic [15:0]         s1n, s2n;
   logic [DIM_BITS:0]   bir_inc, row_inc;
   logic                row_end, img_end;

   always_comb begin
      eff_mode = mode_ff;
      cnt      = cnt_ff;
      filt     = filt_ff;
      drop     = 1'b0;
      if (mode_ff == MD_NEW) begin
         cnt  = '0;
         filt = (bir_ff == '0);
         if (item.func == FUNC_START) begin
            eff_mode = MD_START;
         end else if (phase_ff != PH_RUN) begin
            drop = 1'b1;
         end else if (bf_ff == '0) begin
            eff_mode = MD_BHDR;
         end else begin
            eff_mode = MD_RAW;
         end
      end
   end

   assign cnt_m1 = cnt - STEP_W'(1);
   assign k_al   = cnt[1:0];
   assign k_off  = cnt_m1[1:0];

   // stored block framing
   assign rem_len  = raw_total - off_ff;
   assign blk_last = CMP_W'(rem_len) <= CMP_W'(BLOCK_MAX);
   assign len16    = blk_last ? 16'(rem_len) : 16'(BLOCK_MAX);

   // adler over the raw byte
   assign raw_b = filt ? FILTER_NONE : ~item.pixel_byte;
   assign a1    = {1'b0, adler_ff[15:0]} + {9'h000, raw_b};
   assign s1n   = (a1 >= ADLER_MOD) ? 16'(a1 - ADLER_MOD) : a1[15:0];
   assign a2    = {1'b0, adler_ff[31:16]} + {1'b0, s1n};
   assign s2n   = (a2 >= ADLER_MOD) ? 16'(a2 - ADLER_MOD) : a2[15:0];

   assign bf_inc  = {1'b0, bf_ff} + 17'd1;
   assign bir_inc = {1'b0, bir_ff} + (DIM_BITS+1)'(1);
   assign row_inc = {1'b0, row_ff} + (DIM_BITS+1)'(1);
   assign row_end = bir_inc >= {1'b0, row_len};
   assign img_end = row_end && (row_inc >= {1'b0, img_height});

   always_comb begin
      obyte   = '0;
      use_crc = 1'b0;
      crc_src = crc_ff;
      last    = 1'b0;
      eof     = 1'b0;
      want    = 1'b0;
      hold    = 1'b0;
      unique case (eff_mode)
         MD_START: begin
            want = 1'b1;
            if (cnt == ST_IHDR || cnt == ST_IDAT) begin
               crc_src = CRC_INIT;
            end
            priority if (cnt < ST_LEN) begin
               obyte = PNG_SIG[cnt[2:0]];
            end else if (cnt < ST_IHDR) begin
               obyte = be_byte(IHDR_LEN, k_al);
            end else if (cnt < ST_WIDTH) begin
               obyte   = be_byte(TYPE_IHDR, k_al);
               use_crc = 1'b1;
            end else if (cnt < ST_HEIGHT) begin
               obyte   = be_byte(32'(img_width), k_al);
               use_crc = 1'b1;
            end else if (cnt < ST_DEPTH) begin
               obyte   = be_byte(32'(img_height), k_al);
               use_crc = 1'b1;
            end else if (cnt < ST_CRC) begin
               obyte   = (cnt == ST_DEPTH) ? BIT_DEPTH : 8'h00;
               use_crc = 1'b1;
            end else if (cnt < ST_IDAT_LEN) begin
               obyte = be_byte(~crc_ff, k_off);
            end else if (cnt < ST_IDAT) begin
               obyte = be_byte(idat_len, k_off);
               hold  = !len_ready;
            end else if (cnt < ST_CMF) begin
               obyte   = be_byte(TYPE_IDAT, k_off);
               use_crc = 1'b1;
            end else if (cnt == ST_CMF) begin
               obyte   = ZLIB_CMF;
               use_crc = 1'b1;
            end else begin
               obyte   = ZLIB_FLG;
               use_crc = 1'b1;
               last    = 1'b1;
            end
         end
         MD_BHDR: begin
            want    = 1'b1;
            use_crc = 1'b1;
            priority if (cnt == '0) begin
               obyte = {7'h00, blk_last};
            end else if (cnt == BH_LEN_LO) begin
               obyte = len16[7:0];
            end else if (cnt == BH_LEN_HI) begin
               obyte = len16[15:8];
            end else if (cnt == BH_NLEN_LO) begin
               obyte = ~len16[7:0];
            end else begin
               obyte = ~len16[15:8];
            end
         end
         MD_RAW: begin
            want    = 1'b1;
            use_crc = 1'b1;
            obyte   = raw_b;
            last    = !filt && !img_end;
         end
         MD_FIN: begin
            want = 1'b1;
            if (cnt == FN_IEND) begin
               crc_src = CRC_INIT;
            end
            priority if (cnt < FN_CRC) begin
               obyte   = be_byte(adler_ff, k_al);
               use_crc = 1'b1;
            end else if (cnt < FN_LEN) begin
               obyte = be_byte(~crc_ff, k_al);
            end else if (cnt < FN_IEND) begin
               obyte = 8'h00;
            end else if (cnt < FN_CRC2) begin
               obyte   = be_byte(TYPE_IEND, k_al);
               use_crc = 1'b1;
            end else begin
               obyte = be_byte(~crc_ff, k_al);
               last  = (cnt == FN_LAST);
               eof   = (cnt == FN_LAST);
            end
         end
         default: begin
            want = 1'b0;
         end
      endcase
   end

   assign can_emit  = !rsp_valid_ff || !rsp_stall;
   assign fire      = item_valid && want && !hold && can_emit;
   assign item_done = item_valid && (drop || (fire && last));

   always_comb begin
      phase_in     = phase_ff;
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      filt_in      = filt_ff;
      crc_in       = crc_ff;
      adler_in     = adler_ff;
      bir_in       = bir_ff;
      row_in       = row_ff;
      bf_in        = bf_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ctl          = '0;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{out_byte: obyte, last_of_run: last, end_of_file: eof};
         filt_in      = filt;
         cnt_in       = cnt + STEP_W'(1);
         mode_in      = eff_mode;
         if (use_crc) begin
            crc_in = crc_byte(crc_src, obyte);
         end
         unique case (eff_mode)
            MD_START: begin
               if (cnt == '0) begin
                  ctl.latch = 1'b1;
                  phase_in  = PH_RUN;
                  adler_in  = ADLER_INIT;
                  bir_in    = '0;
                  row_in    = '0;
                  bf_in     = '0;
                  off_in    = '0;
               end
               if (cnt == ST_DIV_LOAD) begin
                  ctl.div_load = 1'b1;
               end
            end
            MD_BHDR: begin
               if (cnt == BH_LAST) begin
                  mode_in = MD_RAW;
                  cnt_in  = '0;
               end
            end
            MD_RAW: begin
               adler_in = {s2n, s1n};
               off_in   = off_ff + TOT_W'(1);
               bf_in    = (bf_inc >= 17'(BLOCK_MAX)) ? 16'h0000 : bf_inc[15:0];
               cnt_in   = '0;
               if (filt) begin
                  filt_in = 1'b0;
                  mode_in = (bf_inc >= 17'(BLOCK_MAX)) ? MD_BHDR : MD_RAW;
               end else if (row_end) begin
                  bir_in = '0;
                  row_in = DIM_BITS'(row_inc);
                  if (img_end) begin
                     mode_in = MD_FIN;
                  end
               end else begin
                  bir_in = DIM_BITS'(bir_inc);
               end
            end
            MD_FIN: begin
               if (cnt == FN_LAST) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
      if (item_done) begin
         mode_in = MD_NEW;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         phase_ff     <= PH_IDLE;
         mode_ff      <= MD_NEW;
         cnt_ff       <= '0;
         filt_ff      <= 1'b0;
         crc_ff       <= CRC_INIT;
         adler_ff     <= ADLER_INIT;
         bir_ff       <= '0;
         row_ff       <= '0;
         bf_ff        <= '0;
         off_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         filt_ff      <= filt_in;
         crc_ff       <= crc_in;
         adler_ff     <= adler_in;
         bir_ff       <= bir_in;
         row_ff       <= row_in;
         bf_ff        <= bf_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/psdw_chk.sv
// port-level checks of the png stored-deflate writer, bound to the top level
// depends on psdw_pkg and png_stored_deflate_writer_macros.svh
`include "png_stored_deflate_writer_macros.svh"

module psdw_chk (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input psdw_pkg::rsp_type rsp_data
);
   import psdw_pkg::*;

   // end of file only ever closes an item's run
   `PSDW_ASSERT_NOW(a_eof_last, rsp_valid && rsp_data.end_of_file, rsp_data.last_of_run)

   // held output item stays put
   `PSDW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // output register empties on reset
   `PSDW_ASSERT_RST(a_rsp_reset, reset, !rsp_valid)

   // trailer is long, so two end-of-file bytes never follow each other
   `PSDW_ASSERT_NEXT(a_eof_once, rsp_valid && !rsp_stall && rsp_data.end_of_file,
                     !(rsp_valid && rsp_data.end_of_file))

endmodule

bind png_stored_deflate_writer psdw_chk u_chk (.*);

FILE: tb/sv/psdw_checker.sv
// checker for the png stored-deflate writer: watches the item and csr ports,
// predicts every output byte and compares them in order; depends on psdw_pkg
module psdw_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  psdw_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  psdw_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [psdw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [psdw_pkg::CFG_W-1:0]     csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import psdw_pkg::*;

   localparam int BLOCK_LIMIT = 65535;

   rsp_type     png_bytes_q[$];
   logic [15:0] reg_width, reg_height;
   logic [31:0] crc_run, adler_run;
   int unsigned row_pos, row_count, blk_fill, rb_lat, h_lat;
   longint unsigned raw_count, raw_total;
   phase_type   img_phase;
   int          fails = 0;

   assign pending = png_bytes_q.size();
   assign fail_count = fails;

   function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      for (int k = 0; k < 8; k++) r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
      return r;
   endfunction

   task automatic put(logic [7:0] b);
      rsp_type e;
      e.out_byte = b;
      e.last_of_run = 1'b0;
      e.end_of_file = 1'b0;
      png_bytes_q.push_back(e);
   endtask

   task automatic put_crc(logic [7:0] b);
      crc_run = crc_next(crc_run, b);
      put(b);
   endtask

   task automatic put_word(logic [31:0] v, bit with_crc);
      for (int s = 3; s >= 0; s--) begin
         if (with_crc) put_crc(v[s*8 +: 8]);
         else put(v[s*8 +: 8]);
      end
   endtask

   task automatic put_raw(logic [7:0] b);
      longint unsigned rem, len;
      logic [15:0] l16;
      int unsigned s1, s2;
      if (blk_fill == 0) begin
         rem = raw_total - raw_count;
         len = (rem < BLOCK_LIMIT) ? rem : BLOCK_LIMIT;
         l16 = len[15:0];
         put_crc((raw_count + len >= raw_total) ? 8'd1 : 8'd0);
         put_crc(l16[7:0]);
         put_crc(l16[15:8]);
         put_crc(~l16[7:0]);
         put_crc(~l16[15:8]);
      end
      put_crc(b);
      s1 = (adler_run[15:0] + b) % 65521;
      s2 = (adler_run[31:16] + s1) % 65521;
      adler_run = {s2[15:0], s1[15:0]};
      raw_count++;
      blk_fill++;
      if (blk_fill >= BLOCK_LIMIT) blk_fill = 0;
   endtask

   task automatic begin_image();
      logic [31:0] w, h, idat_len;
      longint unsigned nblk;
      w = (reg_width == 0) ? 32'd1 : {16'd0, reg_width};
      h = (reg_height == 0) ? 32'd1 : {16'd0, reg_height};
      rb_lat = (w + 7) / 8;
      h_lat = h;
      raw_total = longint'(rb_lat + 1) * h;
      nblk = (raw_total + BLOCK_LIMIT - 1) / BLOCK_LIMIT;
      idat_len = 32'(2 + 5 * nblk + raw_total + 4);
      adler_run = ADLER_INIT;
      row_pos = 0;
      row_count = 0;
      blk_fill = 0;
      raw_count = 0;
      img_phase = PH_RUN;
      for (int i = 0; i < 8; i++) put(PNG_SIG[i]);
      put_word(IHDR_LEN, 0);
      crc_run = CRC_INIT;
      put_word(TYPE_IHDR, 1);
      put_word(w, 1);
      put_word(h, 1);
      put_crc(BIT_DEPTH);
      for (int i = 0; i < 4; i++) put_crc(8'h00);
      put_word(~crc_run, 0);
      put_word(idat_len, 0);
      crc_run = CRC_INIT;
      put_word(TYPE_IDAT, 1);
      put_crc(ZLIB_CMF);
      put_crc(ZLIB_FLG);
   endtask

   task automatic end_image();
      put_word(adler_run, 1);
      put_word(~crc_run, 0);
      put_word(32'd0, 0);
      crc_run = CRC_INIT;
      put_word(TYPE_IEND, 1);
      put_word(~crc_run, 0);
      png_bytes_q[$].end_of_file = 1'b1;
      img_phase = PH_DONE;
   endtask

   task automatic predict_item(req_type it);
      int n0;
      n0 = png_bytes_q.size();
      if (it.func == FUNC_START) begin
         begin_image();
      end else if (img_phase == PH_RUN) begin
         if (row_pos == 0) put_raw(FILTER_NONE);
         put_raw(~it.pixel_byte);
         row_pos++;
         if (row_pos >= rb_lat) begin
            row_pos = 0;
            row_count++;
            if (row_count >= h_lat) end_image();
         end
      end
      if (png_bytes_q.size() > n0) png_bytes_q[$].last_of_run = 1'b1;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch: %s got %0h want %0h", what, got, want);
      fails++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         reg_width <= 16'd1;
         reg_height <= 16'd1;
         crc_run = CRC_INIT;
         adler_run = ADLER_INIT;
         row_pos = 0;
         row_count = 0;
         blk_fill = 0;
         raw_count = 0;
         img_phase = PH_IDLE;
         rb_lat = 1;
         h_lat = 1;
         raw_total = 2;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_IMAGE_WIDTH) reg_width <= csr_wdata;
            else reg_height <= csr_wdata;
         end
         if (req_valid && !req_stall) predict_item(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (png_bytes_q.size() == 0) begin
               report_mismatch("unexpected byte", rsp_data.out_byte, 0);
            end else begin
               want = png_bytes_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
               if (rsp_data.last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", rsp_data.last_of_run, want.last_of_run);
               if (rsp_data.end_of_file !== want.end_of_file)
                  report_mismatch("end_of_file", rsp_data.end_of_file, want.end_of_file);
            end
         end
      end
   end
endmodule

FILE: tb/sv/testbench.sv
// top of the png stored-deflate writer bench: clock, reset, item, csr and stall stimulus,
// verdict; depends on psdw_pkg, png_stored_deflate_writer and psdw_checker
module testbench;
   import psdw_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CFG_W-1:0] csr_wdata = '0;
   int fail_count, pending;
   int items_sent = 0;
   bit quiet = 0;
   int stall_run = 0;
   logic stall_level = 1'b0;

   png_stored_deflate_writer u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   psdw_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_run == 0) begin
            stall_level = quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
            stall_run = gap_len() + 1;
         end
         stall_run--;
         rsp_stall <= stall_level;
      end
   end

   task automatic send_item(logic func, logic [7:0] pix);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.func <= func;
      req_data.pixel_byte <= pix;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(logic [15:0] w, logic [15:0] h);
      drain();
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic run_image(int unsigned npix);
      send_item(FUNC_START, 8'($urandom));
      for (int unsigned i = 0; i < npix; i++) send_item(FUNC_PIXEL, 8'($urandom));
   endtask

   initial begin
      int unsigned w, h, full;
      int r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: dropped while idle, default 1x1, extremes of pixel values
      send_item(FUNC_PIXEL, 8'hFF);
      send_item(FUNC_START, 8'h00);
      send_item(FUNC_PIXEL, 8'h00);
      send_item(FUNC_PIXEL, 8'hA5);
      send_item(FUNC_START, 8'hFF);
      send_item(FUNC_PIXEL, 8'hFF);
      set_geometry(16'd0, 16'd0);
      send_item(FUNC_START, 8'h00);
      send_item(FUNC_PIXEL, 8'h5A);
      set_geometry(16'd9, 16'd2);
      send_item(FUNC_START, 8'h00);
      send_item(FUNC_PIXEL, 8'h55);
      send_item(FUNC_START, 8'h00);
      send_item(FUNC_PIXEL, 8'h55);
      send_item(FUNC_PIXEL, 8'hAA);
      send_item(FUNC_PIXEL, 8'h0F);
      send_item(FUNC_PIXEL, 8'hF0);
      send_item(FUNC_PIXEL, 8'h01);

      // random images, mostly complete, some cut short or followed by noise
      while (items_sent < 400) begin
         if ($urandom_range(0, 3) == 0) begin
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            set_geometry(16'(w), 16'(h));
         end
         quiet = ($urandom_range(0, 4) == 0);
         w = (u_checker.reg_width == 0) ? 1 : u_checker.reg_width;
         h = (u_checker.reg_height == 0) ? 1 : u_checker.reg_height;
         full = ((w + 7) / 8) * h;
         r = $urandom_range(0, 9);
         if (r == 0) run_image($urandom_range(0, full - 1));
         else run_image(full);
         if (r == 1) repeat ($urandom_range(1, 4)) send_item(FUNC_PIXEL, 8'($urandom));
      end

      quiet = 0;
      drain();

      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Mismatches found");
      $finish;
   end
endmodule
